/* rtl/tch_pkg.sv */
// Package: parse phases, state record and result record of the ClientHello parser.
`timescale 1ns / 1ps
package tch_pkg;

	localparam logic [7:0]  HS_TYPE_HELLO = 8'd1;
	localparam logic [23:0] MIN_BODY      = 24'd34;
	localparam logic [15:0] RANDOM_LEN    = 16'd32;
	localparam logic [7:0]  MAX_SID       = 8'd32;
	localparam logic [15:0] EXT_SNI       = 16'd0;
	localparam logic [15:0] EXT_TICKET    = 16'd35;
	localparam logic [7:0]  NAME_HOST     = 8'd0;

	localparam logic [4:0] P_TYPE   = 5'd0;
	localparam logic [4:0] P_LEN0   = 5'd1;
	localparam logic [4:0] P_LEN1   = 5'd2;
	localparam logic [4:0] P_LEN2   = 5'd3;
	localparam logic [4:0] P_VMAJ   = 5'd4;
	localparam logic [4:0] P_VMIN   = 5'd5;
	localparam logic [4:0] P_RAND   = 5'd6;
	localparam logic [4:0] P_SIDLEN = 5'd7;
	localparam logic [4:0] P_SID    = 5'd8;
	localparam logic [4:0] P_CSLEN0 = 5'd9;
	localparam logic [4:0] P_CSLEN1 = 5'd10;
	localparam logic [4:0] P_CS0    = 5'd11;
	localparam logic [4:0] P_CS1    = 5'd12;
	localparam logic [4:0] P_CMLEN  = 5'd13;
	localparam logic [4:0] P_CM     = 5'd14;
	localparam logic [4:0] P_EXLEN0 = 5'd15;
	localparam logic [4:0] P_EXLEN1 = 5'd16;
	localparam logic [4:0] P_EH0    = 5'd17;
	localparam logic [4:0] P_EH1    = 5'd18;
	localparam logic [4:0] P_EH2    = 5'd19;
	localparam logic [4:0] P_EH3    = 5'd20;
	localparam logic [4:0] P_SNL0   = 5'd21;
	localparam logic [4:0] P_SNL1   = 5'd22;
	localparam logic [4:0] P_SNTYPE = 5'd23;
	localparam logic [4:0] P_SNHL0  = 5'd24;
	localparam logic [4:0] P_SNHL1  = 5'd25;
	localparam logic [4:0] P_SNHOST = 5'd26;
	localparam logic [4:0] P_SNSKIP = 5'd27;
	localparam logic [4:0] P_TICKET = 5'd28;
	localparam logic [4:0] P_UNK    = 5'd29;
	localparam logic [4:0] P_DONE   = 5'd30;
	localparam logic [4:0] P_ERR    = 5'd31;

	localparam logic [3:0] K_NONE    = 4'd0;
	localparam logic [3:0] K_VMAJ    = 4'd1;
	localparam logic [3:0] K_VMIN    = 4'd2;
	localparam logic [3:0] K_RANDOM  = 4'd3;
	localparam logic [3:0] K_SID     = 4'd4;
	localparam logic [3:0] K_SUITE   = 4'd5;
	localparam logic [3:0] K_COMP    = 4'd6;
	localparam logic [3:0] K_EXTHDR  = 4'd7;
	localparam logic [3:0] K_HOST    = 4'd8;
	localparam logic [3:0] K_TICKET  = 4'd9;
	localparam logic [3:0] K_UNKNOWN = 4'd10;

	localparam logic [3:0] E_OK        = 4'd0;
	localparam logic [3:0] E_BAD_TYPE  = 4'd1;
	localparam logic [3:0] E_LEN       = 4'd2;
	localparam logic [3:0] E_TRUNC     = 4'd3;
	localparam logic [3:0] E_SID_LONG  = 4'd4;
	localparam logic [3:0] E_SUITES    = 4'd5;
	localparam logic [3:0] E_ZERO_COMP = 4'd6;
	localparam logic [3:0] E_EXT_LEN   = 4'd7;
	localparam logic [3:0] E_EXT_OVER  = 4'd8;
	localparam logic [3:0] E_SNI       = 4'd9;

	typedef struct packed {
		logic [4:0]  phase;
		logic [23:0] msg_left;
		logic [15:0] exts_left;
		logic [15:0] ext_left;
		logic [15:0] list_left;
		logic [15:0] host_left;
		logic [15:0] count;
		logic [7:0]  hi_byte;
		logic [15:0] ext_type;
		logic [3:0]  err;
	} state_t;

	typedef struct packed {
		logic [3:0]  field_kind;
		logic [15:0] field_value;
		logic [15:0] extension_kind;
		logic [15:0] item_index;
		logic        host_start;
		logic        message_done;
		logic        accepted;
		logic [3:0]  error_code;
	} result_t;

	localparam state_t STATE_RESET = '{phase: P_TYPE, msg_left: '0, exts_left: '0,
		ext_left: '0, list_left: '0, host_left: '0, count: '0, hi_byte: '0,
		ext_type: '0, err: E_OK};

endpackage

/* rtl/tch_step.sv */
// Per-byte parse step: next state and result from the current state and one byte.
`timescale 1ns / 1ps
module tch_step (
	input  tch_pkg::state_t  cur,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output tch_pkg::state_t  nxt,
	output tch_pkg::result_t res
);
	import tch_pkg::*;

	state_t      s;
	result_t     o;
	logic        body;
	logic        parse;
	logic [23:0] r;
	logic [15:0] w;
	logic [4:0]  ph;

	always_comb begin
		s = cur;
		o = '0;
		w = {s.hi_byte, data_byte};
		body = ((cur.phase >= P_VMAJ) && (cur.phase <= P_DONE)) ||
			((cur.phase == P_ERR) && (cur.err != E_BAD_TYPE));
		parse = 1'b1;
		if (body) begin
			if (s.msg_left == 24'd0) begin
				s.err = E_LEN;
				s.phase = P_ERR;
				parse = 1'b0;
			end else begin
				s.msg_left = s.msg_left - 24'd1;
			end
		end
		r = s.msg_left;
		ph = s.phase;
		if (parse && ph >= P_EH0 && ph <= P_UNK && s.exts_left != 16'd0)
			s.exts_left = s.exts_left - 16'd1;
		if (parse && ph >= P_SNL0 && ph <= P_UNK && s.ext_left != 16'd0)
			s.ext_left = s.ext_left - 16'd1;
		if (parse && ph >= P_SNTYPE && ph <= P_SNSKIP && s.list_left != 16'd0)
			s.list_left = s.list_left - 16'd1;
		if (ph >= P_EH2 && ph <= P_UNK)
			o.extension_kind = s.ext_type;

		if (parse) begin
			case (ph)
				P_TYPE: begin
					if (data_byte != HS_TYPE_HELLO) s.err = E_BAD_TYPE;
					s.phase = P_LEN0;
				end
				P_LEN0: begin
					s.msg_left = {16'd0, data_byte};
					s.phase = P_LEN1;
				end
				P_LEN1: begin
					s.msg_left = {s.msg_left[15:0], data_byte};
					s.phase = P_LEN2;
				end
				P_LEN2: begin
					s.msg_left = {s.msg_left[15:0], data_byte};
					if (s.err != E_OK) s.phase = P_ERR;
					else if (s.msg_left < MIN_BODY) begin
						s.err = E_TRUNC;
						s.phase = P_ERR;
					end else s.phase = P_VMAJ;
				end
				P_VMAJ: begin
					o.field_kind = K_VMAJ;
					o.field_value = {8'd0, data_byte};
					s.phase = P_VMIN;
				end
				P_VMIN: begin
					o.field_kind = K_VMIN;
					o.field_value = {8'd0, data_byte};
					s.count = '0;
					s.phase = P_RAND;
				end
				P_RAND: begin
					o.field_kind = K_RANDOM;
					o.field_value = {8'd0, data_byte};
					o.item_index = s.count;
					s.count = s.count + 16'd1;
					if (s.count >= RANDOM_LEN) s.phase = P_SIDLEN;
				end
				P_SIDLEN: begin
					s.count = '0;
					s.ext_left = {8'd0, data_byte};
					if (data_byte > MAX_SID) begin
						if (s.err == E_OK) s.err = E_SID_LONG;
						s.phase = P_ERR;
					end else if ({16'd0, data_byte} > r) begin
						if (s.err == E_OK) s.err = E_TRUNC;
						s.phase = P_ERR;
					end else s.phase = (data_byte == 8'd0) ? P_CSLEN0 : P_SID;
				end
				P_SID: begin
					o.field_kind = K_SID;
					o.field_value = {8'd0, data_byte};
					o.item_index = s.count;
					s.count = s.count + 16'd1;
					if (s.ext_left != 16'd0) s.ext_left = s.ext_left - 16'd1;
					if (s.ext_left == 16'd0) s.phase = P_CSLEN0;
				end
				P_CSLEN0: begin
					s.hi_byte = data_byte;
					s.phase = P_CSLEN1;
				end
				P_CSLEN1: begin
					if (w[0] || w == 16'd0) begin
						if (s.err == E_OK) s.err = E_SUITES;
						s.phase = P_ERR;
					end else begin
						s.ext_left = {1'b0, w[15:1]};
						s.count = '0;
						s.phase = P_CS0;
					end
				end
				P_CS0: begin
					s.hi_byte = data_byte;
					s.phase = P_CS1;
				end
				P_CS1: begin
					o.field_kind = K_SUITE;
					o.field_value = w;
					o.item_index = s.count;
					s.count = s.count + 16'd1;
					if (s.ext_left != 16'd0) s.ext_left = s.ext_left - 16'd1;
					s.phase = (s.ext_left == 16'd0) ? P_CMLEN : P_CS0;
				end
				P_CMLEN: begin
					s.count = '0;
					s.ext_left = {8'd0, data_byte};
					if (data_byte == 8'd0) begin
						if (s.err == E_OK) s.err = E_ZERO_COMP;
						s.phase = P_ERR;
					end else if ({16'd0, data_byte} > r) begin
						if (s.err == E_OK) s.err = E_TRUNC;
						s.phase = P_ERR;
					end else s.phase = P_CM;
				end
				P_CM: begin
					o.field_kind = K_COMP;
					o.field_value = {8'd0, data_byte};
					o.item_index = s.count;
					s.count = s.count + 16'd1;
					if (s.ext_left != 16'd0) s.ext_left = s.ext_left - 16'd1;
					if (s.ext_left == 16'd0) s.phase = (r == 24'd0) ? P_DONE : P_EXLEN0;
				end
				P_EXLEN0: begin
					s.hi_byte = data_byte;
					s.phase = P_EXLEN1;
				end
				P_EXLEN1: begin
					if ({8'd0, w} != r) begin
						if (s.err == E_OK) s.err = E_EXT_LEN;
						s.phase = P_ERR;
					end else begin
						s.exts_left = w;
						s.phase = (w == 16'd0) ? P_DONE : P_EH0;
					end
				end
				P_EH0: begin
					if (s.exts_left < 16'd3) begin
						if (s.err == E_OK) s.err = E_EXT_OVER;
						s.phase = P_ERR;
					end else begin
						s.hi_byte = data_byte;
						s.phase = P_EH1;
					end
				end
				P_EH1: begin
					s.ext_type = w;
					o.field_kind = K_EXTHDR;
					o.field_value = w;
					o.extension_kind = w;
					s.phase = P_EH2;
				end
				P_EH2: begin
					s.hi_byte = data_byte;
					s.phase = P_EH3;
				end
				P_EH3: begin
					if (w > s.exts_left) begin
						if (s.err == E_OK) s.err = E_EXT_OVER;
						s.phase = P_ERR;
					end else begin
						s.ext_left = w;
						s.count = '0;
						if (s.ext_type == EXT_SNI) begin
							if (w < 16'd2) begin
								if (s.err == E_OK) s.err = E_SNI;
								s.phase = P_ERR;
							end else s.phase = P_SNL0;
						end else if (w == 16'd0) begin
							s.phase = (s.exts_left == 16'd0) ? P_DONE : P_EH0;
						end else begin
							s.phase = (s.ext_type == EXT_TICKET) ? P_TICKET : P_UNK;
						end
					end
				end
				P_SNL0: begin
					s.hi_byte = data_byte;
					s.phase = P_SNL1;
				end
				P_SNL1: begin
					if (w != s.ext_left) begin
						if (s.err == E_OK) s.err = E_SNI;
						s.phase = P_ERR;
					end else begin
						s.list_left = w;
						if (w == 16'd0) s.phase = (s.exts_left == 16'd0) ? P_DONE : P_EH0;
						else s.phase = P_SNTYPE;
					end
				end
				P_SNTYPE: begin
					if (data_byte == NAME_HOST) begin
						if (s.list_left < 16'd2) begin
							if (s.err == E_OK) s.err = E_SNI;
							s.phase = P_ERR;
						end else s.phase = P_SNHL0;
					end else if (s.list_left == 16'd0) begin
						s.phase = (s.exts_left == 16'd0) ? P_DONE : P_EH0;
					end else s.phase = P_SNSKIP;
				end
				P_SNHL0: begin
					s.hi_byte = data_byte;
					s.phase = P_SNHL1;
				end
				P_SNHL1: begin
					if (w == 16'd0 || w > s.list_left) begin
						if (s.err == E_OK) s.err = E_SNI;
						s.phase = P_ERR;
					end else begin
						s.host_left = w;
						s.count = '0;
						s.phase = P_SNHOST;
					end
				end
				P_SNHOST: begin
					o.field_kind = K_HOST;
					o.field_value = {8'd0, data_byte};
					o.item_index = s.count;
					o.host_start = (s.count == 16'd0);
					s.count = s.count + 16'd1;
					if (s.host_left != 16'd0) s.host_left = s.host_left - 16'd1;
					if (s.host_left == 16'd0) begin
						if (s.list_left == 16'd0)
							s.phase = (s.exts_left == 16'd0) ? P_DONE : P_EH0;
						else s.phase = P_SNTYPE;
					end
				end
				P_SNSKIP: begin
					if (s.list_left == 16'd0)
						s.phase = (s.exts_left == 16'd0) ? P_DONE : P_EH0;
				end
				P_TICKET, P_UNK: begin
					o.field_kind = (ph == P_TICKET) ? K_TICKET : K_UNKNOWN;
					o.field_value = {8'd0, data_byte};
					o.item_index = s.count;
					s.count = s.count + 16'd1;
					if (s.ext_left == 16'd0)
						s.phase = (s.exts_left == 16'd0) ? P_DONE : P_EH0;
				end
				default: begin
				end
			endcase
		end

		// drop field output once the message is in error
		if (s.phase == P_ERR) begin
			o.field_kind = K_NONE;
			o.field_value = '0;
			o.extension_kind = '0;
			o.item_index = '0;
			o.host_start = 1'b0;
		end

		if (last_byte) begin
			o.message_done = 1'b1;
			if (cur.phase <= P_LEN1) o.error_code = E_TRUNC;
			else if (s.err == E_BAD_TYPE) o.error_code = E_BAD_TYPE;
			else if (s.msg_left != 24'd0) o.error_code = E_LEN;
			else if (s.err != E_OK) o.error_code = s.err;
			else if (s.phase != P_DONE) o.error_code = E_TRUNC;
			else o.error_code = E_OK;
			o.accepted = (o.error_code == E_OK);
			s = STATE_RESET;
		end

		nxt = s;
		res = o;
	end

endmodule

/* rtl/tls_client_hello_parser_top.sv */
// Top level: streaming ClientHello parser with parse state and result register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries one message byte per beat in
//   data_byte, with last_byte high on the final byte of the handshake message.
//   Output channel (out_valid / out_stall) returns exactly one result beat per
//   input beat: the field decoded from that byte (field_kind, field_value,
//   extension_kind, item_index, host_start), and on the last byte the
//   verdict (message_done, accepted, error_code).
// Result: registered, it appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while no result waits under out_stall; the
//   per-byte parse step (counter updates and compares) sits between the parse
//   state and result registers, so the next byte can follow in the next cycle.
// Stall: while a result waits under out_stall, in_stall is raised and the
//   parse state holds; a result register that is empty or being drained
//   lets a new byte in.
// Reset: arst_n clears the parse state to "expect handshake type" and drops
//   out_valid. After each last byte the parser returns to that state itself.
module tls_client_hello_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  field_kind,
	output logic [15:0] field_value,
	output logic [15:0] extension_kind,
	output logic [15:0] item_index,
	output logic        host_start,
	output logic        message_done,
	output logic        accepted,
	output logic [3:0]  error_code
);
	import tch_pkg::*;

	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    take;

	// hold the input while the result register is full and stalled
	assign in_stall = out_valid_q & out_stall;
	assign take     = in_valid & ~in_stall;

	tch_step u_step (
		.cur       (state_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// advance parse state only on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; loads only with a new beat
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign field_kind     = res_q.field_kind;
	assign field_value    = res_q.field_value;
	assign extension_kind = res_q.extension_kind;
	assign item_index     = res_q.item_index;
	assign host_start     = res_q.host_start;
	assign message_done   = res_q.message_done;
	assign accepted       = res_q.accepted;
	assign error_code     = res_q.error_code;

endmodule
